// File: rtl/core/osp_pkg.sv
// ----------------------------------------------------------------------------
// Object slot pool package
// Shared widths, operation and status codes, and the control interface
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package osp_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int SLOT_W        = 4;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_TRY   = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } osp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } osp_stat_t;

endpackage

// File: rtl/core/osp_ctrl.sv
// ----------------------------------------------------------------------------
// Object slot pool controller
// Sequences the flag clearing pass after reset, then accepts one transaction,
// executes it and hands the result to the output register.
// ----------------------------------------------------------------------------
module osp_ctrl
    import osp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  osp_stat_t stat,
    output osp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        cmd.clear   = (state_reg == CTRL_CLEAR);
        cmd.capture = (state_reg == CTRL_IDLE) && in_valid;
        cmd.commit  = (state_reg == CTRL_EXEC) && !stat.out_busy;
        in_stall    = (state_reg != CTRL_IDLE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            CTRL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/osp_datapath.sv
// ----------------------------------------------------------------------------
// Object slot pool datapath
// Holds the in-use flag memory, the release queue memory, the queue and
// fresh counters, and the output register.
// ----------------------------------------------------------------------------
module osp_datapath
    import osp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  osp_cmd_t            cmd,
    output osp_stat_t           stat,
    input  logic [OP_W-1:0]     opcode,
    input  logic [SLOT_W-1:0]   slot_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [STATUS_W-1:0] status
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic                flag_mem [SLOTS];
    logic [SLOT_W-1:0]   queue_mem [SLOTS];

    logic [OP_W-1:0]     opcode_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                flag_rd_reg;
    logic [SLOT_W-1:0]   queue_rd_reg;

    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [IDX_W-1:0]    tail_reg;
    logic [IDX_W-1:0]    tail_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    fresh_reg;
    logic [CNT_W-1:0]    fresh_next;
    logic [IDX_W-1:0]    clr_idx_reg;
    logic                out_valid_reg;
    logic [SLOT_W-1:0]   slot_out_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                flag_we;
    logic [IDX_W-1:0]    flag_waddr;
    logic                flag_wdata;
    logic                queue_we;
    logic [SLOT_W-1:0]   res_slot;
    logic [STATUS_W-1:0] res_status;
    logic                queue_nonempty;
    logic                fresh_avail;
    logic                slot_oob;

    assign queue_nonempty = (count_reg != '0);
    assign fresh_avail    = (fresh_reg < CNT_W'(SLOTS));
    assign slot_oob       = (32'(slot_reg) >= 32'(SLOTS));

    assign stat.clear_last = (clr_idx_reg == LAST_IDX);
    assign stat.out_busy   = out_valid_reg && out_stall;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fresh_next = fresh_reg;
        flag_we    = 1'b0;
        flag_waddr = clr_idx_reg;
        flag_wdata = 1'b0;
        queue_we   = 1'b0;
        res_slot   = '0;
        res_status = ST_OK;

        if (cmd.clear)
        begin
            flag_we = 1'b1;
        end
        else
        begin
            unique case (opcode_reg)
                OP_ALLOC, OP_TRY:
                begin
                    if (queue_nonempty)
                    begin
                        res_slot   = queue_rd_reg;
                        flag_we    = 1'b1;
                        flag_waddr = IDX_W'(queue_rd_reg);
                        flag_wdata = 1'b1;
                        head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                    else if (opcode_reg == OP_TRY)
                    begin
                        res_status = ST_NONE;
                    end
                    else if (fresh_avail)
                    begin
                        res_slot   = SLOT_W'(fresh_reg);
                        flag_we    = 1'b1;
                        flag_waddr = IDX_W'(fresh_reg);
                        flag_wdata = 1'b1;
                        fresh_next = fresh_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_status = ST_EXHAUSTED;
                    end
                end
                OP_FREE:
                begin
                    if (slot_oob || !flag_rd_reg)
                    begin
                        res_status = ST_INVALID;
                    end
                    else
                    begin
                        queue_we   = 1'b1;
                        flag_we    = 1'b1;
                        flag_waddr = IDX_W'(slot_reg);
                        flag_wdata = 1'b0;
                        tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
            if (!cmd.commit)
            begin
                flag_we  = 1'b0;
                queue_we = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (queue_we)
        begin
            queue_mem[tail_reg] <= slot_reg;
        end
        if (cmd.capture)
        begin
            opcode_reg   <= opcode;
            slot_reg     <= slot_in;
            flag_rd_reg  <= flag_mem[IDX_W'(slot_in)];
            queue_rd_reg <= queue_mem[head_reg];
        end
        if (cmd.commit)
        begin
            slot_out_reg <= res_slot;
            status_reg   <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                fresh_reg     <= fresh_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign status    = status_reg;

endmodule

// File: rtl/core/object_slot_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// Object slot pool allocator: an accepted transaction is registered with its
// flag and queue memory reads, then committed to the output register once that
// is not stalled; input stalls until the commit. After reset a pass clears every flag.
// ----------------------------------------------------------------------------
module object_slot_pool_allocator_core
    import osp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     opcode,
    input  logic [SLOT_W-1:0]   slot_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [STATUS_W-1:0] status
);

    osp_cmd_t  cmd;
    osp_stat_t stat;

    osp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    osp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .opcode    (opcode),
        .slot_in   (slot_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .slot_out  (slot_out),
        .status    (status)
    );

endmodule
